[src/flow_key_normalize_hash_core_macros.svh]
// Assertion macros used by the checker file of the flow key hash core.
`ifndef FLOW_KEY_NORMALIZE_HASH_CORE_MACROS_SVH
`define FLOW_KEY_NORMALIZE_HASH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FKN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flow key hash check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define FKN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flow key hash check failed");

`endif

[src/fkn_pkg.sv]
// Types, constants and hash step functions of the flow key hash core.
`timescale 1ns / 1ps
`default_nettype none

package fkn_pkg;

    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 1;
    localparam int NUM_HASH_STAGES = 10;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VLAN_AGNOSTIC,
        CFG_MPLS_OVERLAP_MODE
    } cfg_reg_e;

    typedef enum logic [2:0] {
        HOP_LOAD_MIX_A,
        HOP_ADD3_MIX_A,
        HOP_ADD6_MIX_A,
        HOP_ADD9_MIX_A,
        HOP_MIX_B,
        HOP_FINAL_A,
        HOP_FINAL_B
    } hash_op_e;

    // Each mix round is split over two stages, and so is the final step.
    localparam hash_op_e STAGE_OP [NUM_HASH_STAGES] = '{
        HOP_LOAD_MIX_A, HOP_MIX_B,
        HOP_ADD3_MIX_A, HOP_MIX_B,
        HOP_ADD6_MIX_A, HOP_MIX_B,
        HOP_ADD9_MIX_A, HOP_MIX_B,
        HOP_FINAL_A,    HOP_FINAL_B
    };

    typedef struct packed {
        logic [63:0] low_addr_upper;
        logic [63:0] low_addr_lower;
        logic [63:0] high_addr_upper;
        logic [63:0] high_addr_lower;
        logic [15:0] low_side_port;
        logic [15:0] high_side_port;
        logic [7:0]  key_protocol;
        logic [11:0] key_vlan;
        logic [19:0] key_mpls;
    } key_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } abc_t;

    typedef logic [10:0][31:0] word_arr_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic rfc1918(input logic [31:0] ip);
        return (ip[31:24] == 8'h0A) || (ip[31:20] == 12'hAC1) || (ip[31:16] == 16'hC0A8);
    endfunction

    function automatic word_arr_t key_words(input key_t k);
        word_arr_t w;
        w[0]  = k.low_addr_upper[63:32];
        w[1]  = k.low_addr_upper[31:0];
        w[2]  = k.low_addr_lower[63:32];
        w[3]  = k.low_addr_lower[31:0];
        w[4]  = k.high_addr_upper[63:32];
        w[5]  = k.high_addr_upper[31:0];
        w[6]  = k.high_addr_lower[63:32];
        w[7]  = k.high_addr_lower[31:0];
        w[8]  = {k.high_side_port, k.low_side_port};
        w[9]  = {8'h00, k.key_protocol, 4'h0, k.key_vlan};
        w[10] = {12'h000, k.key_mpls};
        return w;
    endfunction

    // First three lines of the lookup3 mix.
    function automatic abc_t mix_first(input abc_t s);
        abc_t r;
        r = s;
        r.a = r.a - r.c; r.a = r.a ^ rotl(r.c, 4);  r.c = r.c + r.b;
        r.b = r.b - r.a; r.b = r.b ^ rotl(r.a, 6);  r.a = r.a + r.c;
        r.c = r.c - r.b; r.c = r.c ^ rotl(r.b, 8);  r.b = r.b + r.a;
        return r;
    endfunction

    // Last three lines of the lookup3 mix.
    function automatic abc_t mix_second(input abc_t s);
        abc_t r;
        r = s;
        r.a = r.a - r.c; r.a = r.a ^ rotl(r.c, 16); r.c = r.c + r.b;
        r.b = r.b - r.a; r.b = r.b ^ rotl(r.a, 19); r.a = r.a + r.c;
        r.c = r.c - r.b; r.c = r.c ^ rotl(r.b, 4);  r.b = r.b + r.a;
        return r;
    endfunction

    function automatic abc_t final_first(input abc_t s);
        abc_t r;
        r = s;
        r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 14);
        r.a = r.a ^ r.c; r.a = r.a - rotl(r.c, 11);
        r.b = r.b ^ r.a; r.b = r.b - rotl(r.a, 25);
        r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 16);
        return r;
    endfunction

    function automatic abc_t final_second(input abc_t s);
        abc_t r;
        r = s;
        r.a = r.a ^ r.c; r.a = r.a - rotl(r.c, 4);
        r.b = r.b ^ r.a; r.b = r.b - rotl(r.a, 14);
        r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 24);
        return r;
    endfunction

    function automatic abc_t hash_step(input hash_op_e op, input key_t k, input abc_t s);
        word_arr_t w;
        abc_t      r;
        w = key_words(k);
        r = s;
        case (op)
            HOP_LOAD_MIX_A:
            begin
                r.a = w[0];
                r.b = w[1];
                r.c = w[2];
                r = mix_first(r);
            end
            HOP_ADD3_MIX_A:
            begin
                r.a = r.a + w[3];
                r.b = r.b + w[4];
                r.c = r.c + w[5];
                r = mix_first(r);
            end
            HOP_ADD6_MIX_A:
            begin
                r.a = r.a + w[6];
                r.b = r.b + w[7];
                r.c = r.c + w[8];
                r = mix_first(r);
            end
            HOP_ADD9_MIX_A:
            begin
                r.a = r.a + w[9];
                r.b = r.b + w[10];
                r = mix_first(r);
            end
            HOP_MIX_B:   r = mix_second(r);
            HOP_FINAL_A: r = final_first(r);
            HOP_FINAL_B: r = final_second(r);
            default:     r = s;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[src/fkn_if.sv]
// Valid/ready channel interfaces for header tuples and flow key results.
`timescale 1ns / 1ps
`default_nettype none

interface fkn_in_if;
    logic        valid;
    logic        ready;
    logic        is_ipv4;
    logic [63:0] src_addr_upper;
    logic [63:0] src_addr_lower;
    logic [63:0] dst_addr_upper;
    logic [63:0] dst_addr_lower;
    logic [15:0] src_port_in;
    logic [15:0] dst_port_in;
    logic [7:0]  ip_protocol;
    logic [11:0] vlan_id;
    logic [19:0] mpls_label_in;

    modport source (
        output valid, is_ipv4, src_addr_upper, src_addr_lower, dst_addr_upper,
               dst_addr_lower, src_port_in, dst_port_in, ip_protocol, vlan_id,
               mpls_label_in,
        input  ready
    );

    modport sink (
        input  valid, is_ipv4, src_addr_upper, src_addr_lower, dst_addr_upper,
               dst_addr_lower, src_port_in, dst_port_in, ip_protocol, vlan_id,
               mpls_label_in,
        output ready
    );
endinterface

interface fkn_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] low_addr_upper;
    logic [63:0] low_addr_lower;
    logic [63:0] high_addr_upper;
    logic [63:0] high_addr_lower;
    logic [15:0] low_side_port;
    logic [15:0] high_side_port;
    logic [7:0]  key_protocol;
    logic [11:0] key_vlan;
    logic [19:0] key_mpls;
    logic [31:0] flow_hash;

    modport source (
        output valid, low_addr_upper, low_addr_lower, high_addr_upper,
               high_addr_lower, low_side_port, high_side_port, key_protocol,
               key_vlan, key_mpls, flow_hash,
        input  ready
    );

    modport sink (
        input  valid, low_addr_upper, low_addr_lower, high_addr_upper,
               high_addr_lower, low_side_port, high_side_port, key_protocol,
               key_vlan, key_mpls, flow_hash,
        output ready
    );
endinterface

`default_nettype wire

[src/fkn_normalize.sv]
// First pipeline stage: orders the endpoints and masks the key fields.
`timescale 1ns / 1ps
`default_nettype none

module fkn_normalize (
    input  wire logic          clk,
    input  wire logic          rst_n,
    fkn_in_if.sink             hdr,
    input  wire logic          vlan_agnostic,
    input  wire logic          mpls_overlap_mode,
    output fkn_pkg::key_t      key,
    output logic               key_valid,
    input  wire logic          key_ready
);

    logic          valid_reg;
    fkn_pkg::key_t key_reg;
    fkn_pkg::key_t key_next;

    logic        ports_used;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [31:0] s32;
    logic [31:0] d32;
    logic        less;
    logic        equal;
    logic        keep_mpls;

    always_comb
    begin
        ports_used = (hdr.ip_protocol == fkn_pkg::PROTO_TCP) ||
                     (hdr.ip_protocol == fkn_pkg::PROTO_UDP);
        sp  = ports_used ? hdr.src_port_in : 16'h0000;
        dp  = ports_used ? hdr.dst_port_in : 16'h0000;
        s32 = hdr.src_addr_upper[63:32];
        d32 = hdr.dst_addr_upper[63:32];

        // IPv4 orders on the top word alone; IPv6 on the whole 128 bits.
        if (hdr.is_ipv4)
        begin
            less  = s32 < d32;
            equal = s32 == d32;
            keep_mpls = mpls_overlap_mode && fkn_pkg::rfc1918(s32) &&
                        fkn_pkg::rfc1918(d32);
        end
        else
        begin
            less  = {hdr.src_addr_upper, hdr.src_addr_lower} <
                    {hdr.dst_addr_upper, hdr.dst_addr_lower};
            equal = {hdr.src_addr_upper, hdr.src_addr_lower} ==
                    {hdr.dst_addr_upper, hdr.dst_addr_lower};
            keep_mpls = mpls_overlap_mode;
        end

        if (less || equal)
        begin
            key_next.low_addr_upper  = hdr.src_addr_upper;
            key_next.low_addr_lower  = hdr.src_addr_lower;
            key_next.high_addr_upper = hdr.dst_addr_upper;
            key_next.high_addr_lower = hdr.dst_addr_lower;
            if (less || (sp < dp))
            begin
                key_next.low_side_port  = sp;
                key_next.high_side_port = dp;
            end
            else
            begin
                key_next.low_side_port  = dp;
                key_next.high_side_port = sp;
            end
        end
        else
        begin
            key_next.low_addr_upper  = hdr.dst_addr_upper;
            key_next.low_addr_lower  = hdr.dst_addr_lower;
            key_next.high_addr_upper = hdr.src_addr_upper;
            key_next.high_addr_lower = hdr.src_addr_lower;
            key_next.low_side_port   = dp;
            key_next.high_side_port  = sp;
        end

        key_next.key_protocol = hdr.ip_protocol;
        key_next.key_vlan     = vlan_agnostic ? 12'h000 : hdr.vlan_id;
        key_next.key_mpls     = keep_mpls ? hdr.mpls_label_in : 20'h00000;
    end

    assign hdr.ready = !valid_reg || key_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (hdr.ready)
        begin
            valid_reg <= hdr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr.ready && hdr.valid)
        begin
            key_reg <= key_next;
        end
    end

    assign key       = key_reg;
    assign key_valid = valid_reg;

endmodule

`default_nettype wire

[src/fkn_hash_pipe.sv]
// Lookup3 hash pipeline: four split mix rounds and a split final step.
`timescale 1ns / 1ps
`default_nettype none

module fkn_hash_pipe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fkn_pkg::key_t key,
    input  wire logic          key_valid,
    output logic               key_ready,
    fkn_out_if.source          flow
);

    localparam int N = fkn_pkg::NUM_HASH_STAGES;

    logic          valid_reg [N];
    fkn_pkg::key_t key_reg   [N];
    fkn_pkg::abc_t abc_reg   [N];
    logic          stage_ready [N+1];

    assign stage_ready[N] = flow.ready;
    assign key_ready      = stage_ready[0];

    for (genvar j = 0; j < N; j++)
    begin : g_stage
        logic          valid_in;
        fkn_pkg::key_t key_in;
        fkn_pkg::abc_t abc_in;
        fkn_pkg::abc_t abc_next;

        if (j == 0)
        begin : g_head
            assign valid_in = key_valid;
            assign key_in   = key;
            assign abc_in   = '0;
        end
        else
        begin : g_body
            assign valid_in = valid_reg[j-1];
            assign key_in   = key_reg[j-1];
            assign abc_in   = abc_reg[j-1];
        end

        // A stage takes a new word when it is empty or its word moves on.
        assign stage_ready[j] = !valid_reg[j] || stage_ready[j+1];
        assign abc_next = fkn_pkg::hash_step(fkn_pkg::STAGE_OP[j], key_in, abc_in);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (stage_ready[j])
            begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[j] && valid_in)
            begin
                key_reg[j] <= key_in;
                abc_reg[j] <= abc_next;
            end
        end
    end

    assign flow.valid           = valid_reg[N-1];
    assign flow.low_addr_upper  = key_reg[N-1].low_addr_upper;
    assign flow.low_addr_lower  = key_reg[N-1].low_addr_lower;
    assign flow.high_addr_upper = key_reg[N-1].high_addr_upper;
    assign flow.high_addr_lower = key_reg[N-1].high_addr_lower;
    assign flow.low_side_port   = key_reg[N-1].low_side_port;
    assign flow.high_side_port  = key_reg[N-1].high_side_port;
    assign flow.key_protocol    = key_reg[N-1].key_protocol;
    assign flow.key_vlan        = key_reg[N-1].key_vlan;
    assign flow.key_mpls        = key_reg[N-1].key_mpls;
    assign flow.flow_hash       = abc_reg[N-1].c;

endmodule

`default_nettype wire

[src/flow_key_normalize_hash_core.sv]
// Top level of the flow key normalize and hash core.
//
//   Port    Direction  Word
//   hdr     in         one packet header tuple
//   flow    out        ordered flow key and its lookup3 hash
//   cfg_*   in         register write: index 0 vlan_agnostic, 1 mpls_overlap_mode
//
// The path has one key-ordering stage, then ten hash stages (each mix round
// and the final step take two stages). One word enters per cycle while the
// output is not stalled. Each stage holds its word while the stage after it
// is full and stalled, so bubbles are squeezed out and nothing is dropped.
// Reset clears the stage valid bits and both registers.
`timescale 1ns / 1ps
`default_nettype none

module flow_key_normalize_hash_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    fkn_in_if.sink                             hdr,
    fkn_out_if.source                          flow,
    input  wire logic                          cfg_wr_en,
    input  wire logic [fkn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fkn_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    logic          vlan_agnostic_reg;
    logic          mpls_overlap_mode_reg;
    fkn_pkg::key_t key;
    logic          key_valid;
    logic          key_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlan_agnostic_reg     <= 1'b0;
            mpls_overlap_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (fkn_pkg::cfg_reg_e'(cfg_index))
                fkn_pkg::CFG_VLAN_AGNOSTIC:     vlan_agnostic_reg     <= cfg_wr_data[0];
                fkn_pkg::CFG_MPLS_OVERLAP_MODE: mpls_overlap_mode_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    fkn_normalize u_normalize (
        .clk               (clk),
        .rst_n             (rst_n),
        .hdr               (hdr),
        .vlan_agnostic     (vlan_agnostic_reg),
        .mpls_overlap_mode (mpls_overlap_mode_reg),
        .key               (key),
        .key_valid         (key_valid),
        .key_ready         (key_ready)
    );

    fkn_hash_pipe u_hash_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .flow      (flow)
    );

endmodule

`default_nettype wire

[src/fkn_checker.sv]
// Port-level checks on the flow key output, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "flow_key_normalize_hash_core_macros.svh"

module fkn_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        flow_valid,
    input wire logic        flow_ready,
    input wire logic [63:0] low_addr_upper,
    input wire logic [63:0] low_addr_lower,
    input wire logic [63:0] high_addr_upper,
    input wire logic [63:0] high_addr_lower,
    input wire logic [15:0] low_side_port,
    input wire logic [15:0] high_side_port,
    input wire logic [7:0]  key_protocol,
    input wire logic [31:0] flow_hash
);

    `FKN_ASSERT_NEXT(a_valid_held, flow_valid && !flow_ready, flow_valid)
    `FKN_ASSERT_NEXT(a_word_held, flow_valid && !flow_ready,
                     $stable(flow_hash) && $stable(low_side_port))

    // Ports count only for TCP and UDP.
    `FKN_ASSERT_NOW(a_ports_zeroed,
                    flow_valid && key_protocol != fkn_pkg::PROTO_TCP &&
                    key_protocol != fkn_pkg::PROTO_UDP,
                    low_side_port == 16'h0000 && high_side_port == 16'h0000)

    // With both endpoints at one address, the ports come out ascending.
    `FKN_ASSERT_NOW(a_equal_addr_ports,
                    flow_valid && low_addr_upper == high_addr_upper &&
                    low_addr_lower == high_addr_lower,
                    low_side_port <= high_side_port)

endmodule

bind flow_key_normalize_hash_core fkn_checker u_fkn_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .flow_valid      (flow.valid),
    .flow_ready      (flow.ready),
    .low_addr_upper  (flow.low_addr_upper),
    .low_addr_lower  (flow.low_addr_lower),
    .high_addr_upper (flow.high_addr_upper),
    .high_addr_lower (flow.high_addr_lower),
    .low_side_port   (flow.low_side_port),
    .high_side_port  (flow.high_side_port),
    .key_protocol    (flow.key_protocol),
    .flow_hash       (flow.flow_hash)
);

`default_nettype wire

[bench/tb_flow_key_normalize_hash_core.sv]
// Self-checking testbench for the flow key normalize and hash core.
`timescale 1ns / 1ps

module tb_flow_key_normalize_hash_core;

    // Register indexes past the end of the register list; writes there are ignored.
    localparam logic [fkn_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [fkn_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic        is_ipv4;
        logic [63:0] src_addr_upper;
        logic [63:0] src_addr_lower;
        logic [63:0] dst_addr_upper;
        logic [63:0] dst_addr_lower;
        logic [15:0] src_port_in;
        logic [15:0] dst_port_in;
        logic [7:0]  ip_protocol;
        logic [11:0] vlan_id;
        logic [19:0] mpls_label_in;
    } tuple_t;

    typedef struct {
        logic [63:0] low_addr_upper;
        logic [63:0] low_addr_lower;
        logic [63:0] high_addr_upper;
        logic [63:0] high_addr_lower;
        logic [15:0] low_side_port;
        logic [15:0] high_side_port;
        logic [7:0]  key_protocol;
        logic [11:0] key_vlan;
        logic [19:0] key_mpls;
        logic [31:0] flow_hash;
    } flow_key_rec_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } hash_state_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [fkn_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fkn_pkg::CFG_DATA_W-1:0] cfg_wr_data;

    fkn_in_if  hdr_ch ();
    fkn_out_if flow_ch ();

    flow_key_normalize_hash_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .hdr         (hdr_ch),
        .flow        (flow_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // Copy of the two registers as the core should hold them.
    logic vlan_agnostic_q;
    logic mpls_overlap_q;

    flow_key_rec_t flow_key_q[$];
    int            mismatch_count;
    int unsigned   send_idle_pct;
    int unsigned   recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic hash_state_t lookup3_mix(input hash_state_t s);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = s.a;
        b = s.b;
        c = s.c;
        a -= c; a ^= rol32(c, 4);  c += b;
        b -= a; b ^= rol32(a, 6);  a += c;
        c -= b; c ^= rol32(b, 8);  b += a;
        a -= c; a ^= rol32(c, 16); c += b;
        b -= a; b ^= rol32(a, 19); a += c;
        c -= b; c ^= rol32(b, 4);  b += a;
        return '{a, b, c};
    endfunction

    function automatic logic [31:0] lookup3_final_c(input hash_state_t s);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = s.a;
        b = s.b;
        c = s.c;
        c ^= b; c -= rol32(b, 14);
        a ^= c; a -= rol32(c, 11);
        b ^= a; b -= rol32(a, 25);
        c ^= b; c -= rol32(b, 16);
        a ^= c; a -= rol32(c, 4);
        b ^= a; b -= rol32(a, 14);
        c ^= b; c -= rol32(b, 24);
        return c;
    endfunction

    function automatic logic is_private_v4(input logic [31:0] ip);
        return (ip[31:24] == 8'd10) || (ip[31:20] == {8'd172, 4'h1}) ||
               (ip[31:16] == {8'd192, 8'd168});
    endfunction

    function automatic flow_key_rec_t predict_flow_key(input tuple_t t);
        flow_key_rec_t r;
        logic [15:0]   sp;
        logic [15:0]   dp;
        logic [127:0]  sa;
        logic [127:0]  da;
        logic          src_less;
        logic          same_addr;
        logic          keep_label;
        logic [31:0]   w [11];
        hash_state_t   h;
        sp = t.src_port_in;
        dp = t.dst_port_in;
        if (t.ip_protocol != fkn_pkg::PROTO_TCP && t.ip_protocol != fkn_pkg::PROTO_UDP)
        begin
            sp = '0;
            dp = '0;
        end
        sa = {t.src_addr_upper, t.src_addr_lower};
        da = {t.dst_addr_upper, t.dst_addr_lower};
        if (t.is_ipv4)
        begin
            src_less  = sa[127:96] < da[127:96];
            same_addr = sa[127:96] == da[127:96];
        end
        else
        begin
            src_less  = sa < da;
            same_addr = sa == da;
        end
        if (src_less || same_addr)
        begin
            {r.low_addr_upper, r.low_addr_lower}   = sa;
            {r.high_addr_upper, r.high_addr_lower} = da;
            // With equal addresses the ports alone decide the order.
            if (src_less || sp < dp)
            begin
                r.low_side_port  = sp;
                r.high_side_port = dp;
            end
            else
            begin
                r.low_side_port  = dp;
                r.high_side_port = sp;
            end
        end
        else
        begin
            {r.low_addr_upper, r.low_addr_lower}   = da;
            {r.high_addr_upper, r.high_addr_lower} = sa;
            r.low_side_port  = dp;
            r.high_side_port = sp;
        end
        keep_label = mpls_overlap_q &&
                     (!t.is_ipv4 || (is_private_v4(sa[127:96]) && is_private_v4(da[127:96])));
        r.key_mpls     = keep_label ? t.mpls_label_in : '0;
        r.key_vlan     = vlan_agnostic_q ? '0 : t.vlan_id;
        r.key_protocol = t.ip_protocol;

        w[0]  = r.low_addr_upper[63:32];
        w[1]  = r.low_addr_upper[31:0];
        w[2]  = r.low_addr_lower[63:32];
        w[3]  = r.low_addr_lower[31:0];
        w[4]  = r.high_addr_upper[63:32];
        w[5]  = r.high_addr_upper[31:0];
        w[6]  = r.high_addr_lower[63:32];
        w[7]  = r.high_addr_lower[31:0];
        w[8]  = {r.high_side_port, r.low_side_port};
        w[9]  = {8'h00, r.key_protocol, 4'h0, r.key_vlan};
        w[10] = {12'h000, r.key_mpls};

        h = '{w[0], w[1], w[2]};
        h = lookup3_mix(h);
        for (int i = 3; i <= 6; i += 3)
        begin
            h.a += w[i];
            h.b += w[i + 1];
            h.c += w[i + 2];
            h = lookup3_mix(h);
        end
        h.a += w[9];
        h.b += w[10];
        h = lookup3_mix(h);
        r.flow_hash = lookup3_final_c(h);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result side: random backpressure, then compare each accepted word.
    always @(negedge clk)
    begin
        flow_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        flow_key_rec_t want;
        if (rst_n && flow_ch.valid && flow_ch.ready)
        begin
            if (flow_key_q.size() == 0)
            begin
                $error("flow word with no expectation pending, hash %h", flow_ch.flow_hash);
                mismatch_count++;
            end
            else
            begin
                want = flow_key_q.pop_front();
                check_field("low_addr_upper", want.low_addr_upper, flow_ch.low_addr_upper);
                check_field("low_addr_lower", want.low_addr_lower, flow_ch.low_addr_lower);
                check_field("high_addr_upper", want.high_addr_upper, flow_ch.high_addr_upper);
                check_field("high_addr_lower", want.high_addr_lower, flow_ch.high_addr_lower);
                check_field("low_side_port", 64'(want.low_side_port),
                            64'(flow_ch.low_side_port));
                check_field("high_side_port", 64'(want.high_side_port),
                            64'(flow_ch.high_side_port));
                check_field("key_protocol", 64'(want.key_protocol),
                            64'(flow_ch.key_protocol));
                check_field("key_vlan", 64'(want.key_vlan), 64'(flow_ch.key_vlan));
                check_field("key_mpls", 64'(want.key_mpls), 64'(flow_ch.key_mpls));
                check_field("flow_hash", 64'(want.flow_hash), 64'(flow_ch.flow_hash));
            end
        end
    end

    // All driving tasks are entered and left just after a falling edge.
    task automatic send_tuple(input tuple_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hdr_ch.valid <= 1'b0;
            @(negedge clk);
        end
        hdr_ch.valid          <= 1'b1;
        hdr_ch.is_ipv4        <= t.is_ipv4;
        hdr_ch.src_addr_upper <= t.src_addr_upper;
        hdr_ch.src_addr_lower <= t.src_addr_lower;
        hdr_ch.dst_addr_upper <= t.dst_addr_upper;
        hdr_ch.dst_addr_lower <= t.dst_addr_lower;
        hdr_ch.src_port_in    <= t.src_port_in;
        hdr_ch.dst_port_in    <= t.dst_port_in;
        hdr_ch.ip_protocol    <= t.ip_protocol;
        hdr_ch.vlan_id        <= t.vlan_id;
        hdr_ch.mpls_label_in  <= t.mpls_label_in;
        @(posedge clk);
        while (!hdr_ch.ready)
            @(posedge clk);
        flow_key_q.push_back(predict_flow_key(t));
        @(negedge clk);
    endtask

    task automatic wait_flow_drained();
        hdr_ch.valid <= 1'b0;
        while (flow_key_q.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Only called while the pipeline is empty.
    task automatic write_reg(input logic [fkn_pkg::CFG_IDX_W-1:0] idx, input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        if (idx == fkn_pkg::CFG_VLAN_AGNOSTIC)
            vlan_agnostic_q = value;
        else if (idx == fkn_pkg::CFG_MPLS_OVERLAP_MODE)
            mpls_overlap_q = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic tuple_t make_tuple(input logic v4,
                                          input logic [63:0] su, input logic [63:0] sl,
                                          input logic [63:0] du, input logic [63:0] dl,
                                          input logic [15:0] sp, input logic [15:0] dp,
                                          input logic [7:0] proto, input logic [11:0] vlan,
                                          input logic [19:0] mpls);
        tuple_t t;
        t.is_ipv4        = v4;
        t.src_addr_upper = su;
        t.src_addr_lower = sl;
        t.dst_addr_upper = du;
        t.dst_addr_lower = dl;
        t.src_port_in    = sp;
        t.dst_port_in    = dp;
        t.ip_protocol    = proto;
        t.vlan_id        = vlan;
        t.mpls_label_in  = mpls;
        return t;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_v4_addr();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0, 1: return {8'd10, r[23:0]};
            2, 3: return {8'd172, 4'h1, r[19:0]};
            4, 5: return {8'd192, 8'd168, r[15:0]};
            6:    return {8'd172, r[0] ? 4'h2 : 4'h0, r[19:0]};
            7:    return {r[0] ? 8'd11 : 8'd9, r[23:0]};
            8:    return {8'd192, r[0] ? 8'd169 : 8'd167, r[15:0]};
            default: return r;
        endcase
    endfunction

    function automatic tuple_t rand_tuple();
        tuple_t      t;
        logic [31:0] r;
        t = make_tuple(1'($urandom_range(1)), rand64(), rand64(), rand64(), rand64(),
                       16'($urandom), 16'($urandom), 8'($urandom), 12'($urandom),
                       20'($urandom));
        if (t.is_ipv4)
        begin
            t.src_addr_upper[63:32] = rand_v4_addr();
            t.dst_addr_upper[63:32] = rand_v4_addr();
            // Mostly clean IPv4 words, but sometimes junk below the address.
            if ($urandom_range(3) != 0)
            begin
                t.src_addr_upper[31:0] = '0;
                t.src_addr_lower       = '0;
                t.dst_addr_upper[31:0] = '0;
                t.dst_addr_lower       = '0;
            end
        end
        case ($urandom_range(9))
            0:
            begin
                t.dst_addr_upper = t.src_addr_upper;
                t.dst_addr_lower = t.src_addr_lower;
            end
            1: t.dst_addr_upper[63:32] = t.src_addr_upper[63:32];
            2: t.dst_addr_upper = t.src_addr_upper;
            default: ;
        endcase
        r = $urandom;
        case (r[3:0])
            0, 1, 2, 3, 4: t.ip_protocol = fkn_pkg::PROTO_TCP;
            5, 6, 7, 8:    t.ip_protocol = fkn_pkg::PROTO_UDP;
            9:             t.ip_protocol = r[4] ? 8'hFF : 8'h00;
            default: ;
        endcase
        case (r[7:5])
            0: t.dst_port_in = t.src_port_in;
            1: t.src_port_in = r[8] ? 16'hFFFF : 16'h0000;
            default: ;
        endcase
        return t;
    endfunction

    task automatic test_field_extremes();
        logic [63:0] lo_bits;
        lo_bits = 64'hDEAD_BEEF_0123_4567;
        send_tuple(make_tuple(1'b0, '0, '0, '0, '0, '0, '0, 8'h00, '0, '0));
        send_tuple(make_tuple(1'b0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                              16'hFFFF, 16'hFFFF, 8'hFF, 12'hFFF, 20'hFFFFF));
        send_tuple(make_tuple(1'b1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                              16'hFFFF, 16'h0000, fkn_pkg::PROTO_TCP, 12'hFFF, 20'hFFFFF));
        // Full 128-bit ordering for IPv6, in both directions.
        send_tuple(make_tuple(1'b0, 64'h1, ALL_ONES, 64'h2, '0,
                              16'd1, 16'hFFFF, fkn_pkg::PROTO_TCP, 12'h001, 20'h00001));
        send_tuple(make_tuple(1'b0, 64'h8000_0000_0000_0000, '0, 64'h7FFF_FFFF_FFFF_FFFF,
                              ALL_ONES, 16'h1234, 16'h4321, fkn_pkg::PROTO_UDP, 12'h800,
                              20'h80000));
        send_tuple(make_tuple(1'b0, 64'h55, 64'h10, 64'h55, 64'h0F,
                              16'h0050, 16'hC000, fkn_pkg::PROTO_TCP, 12'h7FF, 20'h7FFFF));
        // Equal addresses: ports are put in order instead.
        send_tuple(make_tuple(1'b0, lo_bits, ~lo_bits, lo_bits, ~lo_bits,
                              16'hF000, 16'h0F00, fkn_pkg::PROTO_TCP, 12'h123, 20'h12345));
        send_tuple(make_tuple(1'b0, lo_bits, ~lo_bits, lo_bits, ~lo_bits,
                              16'h0001, 16'hFFFE, fkn_pkg::PROTO_UDP, 12'h456, 20'hABCDE));
        send_tuple(make_tuple(1'b0, lo_bits, lo_bits, lo_bits, lo_bits,
                              16'h2222, 16'h2222, fkn_pkg::PROTO_UDP, 12'h000, 20'h00000));
        // IPv4 looks only at the top word; the rest travels with its address.
        send_tuple(make_tuple(1'b1, {32'h0A00_0001, 32'h1}, lo_bits,
                              {32'h0A00_0001, 32'h0}, ~lo_bits,
                              16'h9000, 16'h0100, fkn_pkg::PROTO_UDP, 12'h321, 20'h54321));
        send_tuple(make_tuple(1'b1, {32'hC0A8_0102, 32'h0}, '0,
                              {32'hC0A8_0101, 32'hFFFF_FFFF}, ALL_ONES,
                              16'd80, 16'd443, fkn_pkg::PROTO_TCP, 12'h00A, 20'h0000A));
        send_tuple(make_tuple(1'b1, {32'h0A00_0000, 32'hFFFF_FFFF}, ALL_ONES,
                              {32'h0A00_0001, 32'h0}, '0,
                              16'd53, 16'd53, fkn_pkg::PROTO_UDP, 12'hFFF, 20'hFFFFF));
        // Protocol numbers next to TCP and UDP must zero the ports.
        send_tuple(make_tuple(1'b1, {32'hAC10_0001, 32'h0}, '0, {32'h0101_0101, 32'h0}, '0,
                              16'hAAAA, 16'h5555, 8'd5, 12'h111, 20'h11111));
        send_tuple(make_tuple(1'b1, {32'hAC10_0001, 32'h0}, '0, {32'h0101_0101, 32'h0}, '0,
                              16'hAAAA, 16'h5555, 8'd7, 12'h222, 20'h22222));
        send_tuple(make_tuple(1'b0, 64'h9, '0, 64'h3, '0,
                              16'h5555, 16'hAAAA, 8'd16, 12'h333, 20'h33333));
        send_tuple(make_tuple(1'b0, 64'h9, '0, 64'h3, '0,
                              16'h5555, 16'hAAAA, 8'd18, 12'h444, 20'h44444));
    endtask

    task automatic test_register_modes();
        logic [31:0] v4_a [8];
        logic [31:0] v4_b [8];
        v4_a = '{32'h0A00_0001, 32'hAC1F_FFFF, 32'hAC20_0000, 32'hAC0F_FFFF,
                 32'h0AFF_FFFF, 32'h0B00_0000, 32'hC0A8_FFFF, 32'hC0A9_0000};
        v4_b = '{32'hC0A8_0001, 32'hAC10_0000, 32'h0A01_0203, 32'hC0A8_0505,
                 32'hC0A8_0000, 32'h0A00_0000, 32'hAC10_0101, 32'hC0A8_0101};
        for (int mode = 0; mode < 4; mode++)
        begin
            wait_flow_drained();
            case (mode)
                0:
                begin
                    write_reg(fkn_pkg::CFG_VLAN_AGNOSTIC, 1'b0);
                    write_reg(fkn_pkg::CFG_MPLS_OVERLAP_MODE, 1'b0);
                end
                1:
                begin
                    write_reg(fkn_pkg::CFG_VLAN_AGNOSTIC, 1'b1);
                    write_reg(fkn_pkg::CFG_MPLS_OVERLAP_MODE, 1'b1);
                    // Writes past the register list must leave both alone.
                    write_reg(CFG_IDX_SPARE_LO, 1'b0);
                end
                2:
                begin
                    write_reg(fkn_pkg::CFG_MPLS_OVERLAP_MODE, 1'b0);
                    write_reg(CFG_IDX_SPARE_HI, 1'b1);
                end
                default:
                begin
                    write_reg(fkn_pkg::CFG_VLAN_AGNOSTIC, 1'b0);
                    write_reg(fkn_pkg::CFG_MPLS_OVERLAP_MODE, 1'b1);
                    write_reg(CFG_IDX_SPARE_LO, 1'b1);
                end
            endcase
            for (int i = 0; i < 8; i++)
                send_tuple(make_tuple(1'b1, {v4_a[i], 32'h0}, '0, {v4_b[i], 32'h0}, '0,
                                      16'(1000 + i), 16'd2000, fkn_pkg::PROTO_TCP,
                                      12'hABC, 20'hFEDCB));
            send_tuple(make_tuple(1'b0, rand64(), rand64(), rand64(), rand64(),
                                  16'($urandom), 16'($urandom), fkn_pkg::PROTO_UDP,
                                  12'h5A5, 20'hA5A5A));
        end
    endtask

    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int n_items);
        wait_flow_drained();
        send_idle_pct = tx_pct;
        recv_idle_pct <= rx_pct;
        for (int mode = 0; mode < 4; mode++)
        begin
            // Each quarter runs under another register setting, written while empty.
            wait_flow_drained();
            write_reg(fkn_pkg::CFG_VLAN_AGNOSTIC, mode[0]);
            write_reg(fkn_pkg::CFG_MPLS_OVERLAP_MODE, mode[1]);
            for (int i = 0; i < n_items / 4; i++)
                send_tuple(rand_tuple());
        end
    endtask

    initial
    begin
        mismatch_count        = 0;
        vlan_agnostic_q       = 1'b0;
        mpls_overlap_q        = 1'b0;
        send_idle_pct         = 34;
        recv_idle_pct         = 56;
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = fkn_pkg::CFG_VLAN_AGNOSTIC;
        cfg_wr_data           = '0;
        hdr_ch.valid          = 1'b0;
        hdr_ch.is_ipv4        = 1'b0;
        hdr_ch.src_addr_upper = '0;
        hdr_ch.src_addr_lower = '0;
        hdr_ch.dst_addr_upper = '0;
        hdr_ch.dst_addr_lower = '0;
        hdr_ch.src_port_in    = '0;
        hdr_ch.dst_port_in    = '0;
        hdr_ch.ip_protocol    = '0;
        hdr_ch.vlan_id        = '0;
        hdr_ch.mpls_label_in  = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_register_modes();
        test_random_traffic(34, 56, 500);
        test_random_traffic(56, 34, 500);
        test_random_traffic(0, 0, 500);

        wait_flow_drained();
        repeat (24) @(negedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/fkn_pkg.sv
src/fkn_if.sv
src/fkn_normalize.sv
src/fkn_hash_pipe.sv
src/flow_key_normalize_hash_core.sv
src/fkn_checker.sv
bench/tb_flow_key_normalize_hash_core.sv
